// ===== rtl/wft_pkg.sv =====
package wft_pkg;

  localparam int WEIGHT_BITS = 16;
  localparam int TILE        = 6;
  localparam int TAPS        = 3;
  localparam int COUNT_W     = 11;
  localparam int INDEX_W     = 10;
  localparam int ADDR_W      = 26;
  localparam int ROW_W       = 3;
  // first pass (G*g) peaks at 24*2^15, second pass (G*g*G^T) at 576*2^15
  localparam int MID_W       = WEIGHT_BITS + 5;
  localparam int SUM_W       = WEIGHT_BITS + 10;
  // divide by 576 = shift by 6, then divide by 9 through a reciprocal multiply
  localparam int PRE_SHIFT   = 6;
  localparam int HALF_576    = 288;
  localparam int M_W         = SUM_W - PRE_SHIFT;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT - 3;
  localparam int RECIP9      = ((2 ** RECIP_SHIFT) + 8) / 9;
  localparam int PROD_W      = M_W + RECIP_W;
  localparam int Q_W         = WEIGHT_BITS + 1;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TILE - 1);

  // register index, taken from paddr[2]
  localparam logic REG_FILTER_COUNT  = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  typedef logic signed [WEIGHT_BITS-1:0] value_t;
  typedef logic signed [MID_W-1:0]       mid_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef sum_t                          sum6_t [TILE];

  typedef struct packed {
    logic signed [15:0] weight_r0_c0;
    logic signed [15:0] weight_r0_c1;
    logic signed [15:0] weight_r0_c2;
    logic signed [15:0] weight_r1_c0;
    logic signed [15:0] weight_r1_c1;
    logic signed [15:0] weight_r1_c2;
    logic signed [15:0] weight_r2_c0;
    logic signed [15:0] weight_r2_c1;
    logic signed [15:0] weight_r2_c2;
    logic [9:0]         filter_index;
    logic [9:0]         channel_index;
  } weights_t;

  typedef struct packed {
    logic [2:0]         tile_row;
    logic [25:0]        row_address;
    logic signed [15:0] value_col0;
    logic signed [15:0] value_col1;
    logic signed [15:0] value_col2;
    logic signed [15:0] value_col3;
    logic signed [15:0] value_col4;
    logic signed [15:0] value_col5;
    logic               last_of_tile;
  } rows_t;

  // Apply the integer matrix 24*G to one 3-vector (shifts and adds only).
  function automatic sum6_t g_apply(input sum_t a, input sum_t b, input sum_t c);
    sum6_t r;
    r[0] = (a <<< 2) + (a <<< 1);
    r[1] = -((a + b + c) <<< 2);
    r[2] = -((a - b + c) <<< 2);
    r[3] = a + (b <<< 1) + (c <<< 2);
    r[4] = a - (b <<< 1) + (c <<< 2);
    r[5] = (c <<< 4) + (c <<< 3);
    return r;
  endfunction

endpackage

// ===== rtl/wft_row_calc.sv =====
module wft_row_calc
  import wft_pkg::*;
(
  input  mid_t   tmp0,
  input  mid_t   tmp1,
  input  mid_t   tmp2,
  output value_t vals [TILE]
);

  sum6_t s;

  assign s = g_apply(sum_t'(tmp0), sum_t'(tmp1), sum_t'(tmp2));

  // round half away from zero, divide by 576, saturate
  for (genvar j = 0; j < TILE; j++) begin : g_col
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  rnd;
    logic [M_W-1:0]    m;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    q;
    logic              neg;

    always_comb begin
      neg  = s[j][SUM_W-1];
      mag  = neg ? SUM_W'(-s[j]) : SUM_W'(s[j]);
      rnd  = mag + SUM_W'(HALF_576);
      m    = rnd[SUM_W-1:PRE_SHIFT];
      prod = PROD_W'(m) * PROD_W'(RECIP9);
      q    = prod[RECIP_SHIFT +: Q_W];
      if (neg) begin
        if (q > Q_W'(2 ** (WEIGHT_BITS - 1))) begin
          vals[j] = value_t'(Q_W'(2 ** (WEIGHT_BITS - 1)));
        end else begin
          vals[j] = value_t'(-q);
        end
      end else begin
        if (q > Q_W'(2 ** (WEIGHT_BITS - 1) - 1)) begin
          vals[j] = value_t'(Q_W'(2 ** (WEIGHT_BITS - 1) - 1));
        end else begin
          vals[j] = value_t'(q);
        end
      end
    end
  end

endmodule

// ===== rtl/winograd_filter_transform.sv =====
// Winograd F(4x4,3x3) filter transform: one 3x3 filter in, six rows of the 6x6 tile out.
// Row 0 goes from the tile register through the output register; rows follow one a cycle unless rows_stall holds them.
// A new filter waits until the tile in hand has gone out, paced by the single-row result channel.
// The next filter is taken in the cycle its predecessor's last row moves to the output register.
// Reset (synchronous, rst high): no tile or row held, both counts back to one.
module winograd_filter_transform
  import wft_pkg::*;
#(
  parameter int MAX_FILTERS  = 1024,
  parameter int MAX_CHANNELS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // filter channel
  input  logic        weights_valid,
  output logic        weights_stall,
  input  weights_t    weights,
  // result row channel
  output logic        rows_valid,
  input  logic        rows_stall,
  output rows_t       rows,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers: K and C, clamped to their maximum on write.
  // ck follows the counts through a register; stride is derived from ck.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]   filter_count;
  logic [COUNT_W-1:0]   channel_count;
  logic [2*COUNT_W-1:0] ck;
  logic [ADDR_W-1:0]    stride;
  logic                 cfg_wr;
  logic [COUNT_W-1:0]   wdata_count;
  logic [COUNT_W-1:0]   fc_clamped;
  logic [COUNT_W-1:0]   cc_clamped;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign wdata_count = pwdata[COUNT_W-1:0];
  assign fc_clamped  = (32'(wdata_count) > 32'(MAX_FILTERS))  ? COUNT_W'(MAX_FILTERS)
                                                              : wdata_count;
  assign cc_clamped  = (32'(wdata_count) > 32'(MAX_CHANNELS)) ? COUNT_W'(MAX_CHANNELS)
                                                              : wdata_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count  <= COUNT_W'(1);
      channel_count <= COUNT_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FILTER_COUNT:  filter_count  <= fc_clamped;
        REG_CHANNEL_COUNT: channel_count <= cc_clamped;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ck <= (2*COUNT_W)'(1);
    end else begin
      ck <= (2*COUNT_W)'(filter_count) * (2*COUNT_W)'(channel_count);
    end
  end

  // one tile row spans six columns of C*K each
  assign stride = ADDR_W'({ck, 2'b00}) + ADDR_W'({ck, 1'b0});

  always_comb begin
    unique case (paddr[2])
      REG_FILTER_COUNT:  prdata = 32'(filter_count);
      REG_CHANNEL_COUNT: prdata = 32'(channel_count);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tile register: holds G*g (6x3) for the filter being emitted, its row
  // counter and the running address. First pass runs column by column.
  // ---------------------------------------------------------------------------
  value_t            w [TAPS][TAPS];
  sum6_t             col_res [TAPS];
  mid_t              tmp [TILE][TAPS];
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] base_addr;
  logic [ROW_W-1:0]  row_idx;
  logic              t_valid;
  logic              take;
  logic              advance;
  logic              tile_done;

  assign w[0][0] = weights.weight_r0_c0;
  assign w[0][1] = weights.weight_r0_c1;
  assign w[0][2] = weights.weight_r0_c2;
  assign w[1][0] = weights.weight_r1_c0;
  assign w[1][1] = weights.weight_r1_c1;
  assign w[1][2] = weights.weight_r1_c2;
  assign w[2][0] = weights.weight_r2_c0;
  assign w[2][1] = weights.weight_r2_c1;
  assign w[2][2] = weights.weight_r2_c2;

  for (genvar j = 0; j < TAPS; j++) begin : g_first
    assign col_res[j] = g_apply(sum_t'(w[0][j]), sum_t'(w[1][j]), sum_t'(w[2][j]));
  end

  // c*K + k, wraps at the address width
  assign base_addr = ADDR_W'(ADDR_W'(filter_count) * ADDR_W'(weights.channel_index))
                   + ADDR_W'(weights.filter_index);

  // a row moves out when the output register is empty or being drained
  assign advance       = t_valid && (!rows_valid || !rows_stall);
  assign tile_done     = advance && (row_idx == LAST_ROW);
  assign weights_stall = t_valid && !tile_done;
  assign take          = weights_valid && !weights_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      row_idx <= '0;
    end else if (take) begin
      t_valid <= 1'b1;
      row_idx <= '0;
    end else if (tile_done) begin
      t_valid <= 1'b0;
      row_idx <= '0;
    end else if (advance) begin
      row_idx <= row_idx + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < TILE; i++) begin
        for (int j = 0; j < TAPS; j++) begin
          tmp[i][j] <= col_res[j][i][MID_W-1:0];
        end
      end
      addr <= base_addr;
    end else if (advance) begin
      addr <= addr + stride;
    end
  end

  // ---------------------------------------------------------------------------
  // Second pass on the selected row, rounding and saturation, then the
  // output register.
  // ---------------------------------------------------------------------------
  value_t vals [TILE];

  wft_row_calc u_row_calc (
    .tmp0 (tmp[row_idx][0]),
    .tmp1 (tmp[row_idx][1]),
    .tmp2 (tmp[row_idx][2]),
    .vals (vals)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_valid <= 1'b0;
    end else if (advance) begin
      rows_valid <= 1'b1;
    end else if (!rows_stall) begin
      rows_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rows.tile_row     <= row_idx;
      rows.row_address  <= addr;
      rows.value_col0   <= vals[0];
      rows.value_col1   <= vals[1];
      rows.value_col2   <= vals[2];
      rows.value_col3   <= vals[3];
      rows.value_col4   <= vals[4];
      rows.value_col5   <= vals[5];
      rows.last_of_tile <= (row_idx == LAST_ROW);
    end
  end

`ifndef ASSERT_OFF
  // last flag marks exactly the final row of a tile
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    rows_valid |-> (rows.last_of_tile == (rows.tile_row == LAST_ROW)))
    else $error("last_of_tile disagrees with tile_row");

  // rows of a tile leave in order, one per transfer into the output register
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (advance && (row_idx != LAST_ROW) && !take) |=> (row_idx == $past(row_idx) + ROW_W'(1)))
    else $error("tile row skipped or repeated");

  // a tile is never dropped before its last row has gone out
  a_tile_kept: assert property (@(posedge clk) disable iff (rst)
    (t_valid && (row_idx != LAST_ROW)) |=> t_valid)
    else $error("tile register emptied mid-tile");

  // an empty tile register always restarts at row zero
  a_idle_row: assert property (@(posedge clk) disable iff (rst)
    !t_valid |-> (row_idx == '0))
    else $error("row counter not at zero while idle");
`endif

endmodule
